// ----- rtl/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled during reset; expects clk_i and rst_ni in scope.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Implication shorthand on the same clock and reset.
`define ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ----- rtl/i2cm_pkg.sv -----
package i2cm_pkg;

  typedef enum logic [3:0] {
    PH_IDLE    = 4'd0,
    PH_ST_A    = 4'd1,
    PH_ST_B    = 4'd2,
    PH_SP_A    = 4'd3,
    PH_SP_B    = 4'd4,
    PH_SP_C    = 4'd5,
    PH_WR_LOW  = 4'd6,
    PH_WR_DATA = 4'd7,
    PH_WR_HIGH = 4'd8,
    PH_WA_REL  = 4'd9,
    PH_WA_HIGH = 4'd10,
    PH_RD_HIGH = 4'd11,
    PH_RD_LOW  = 4'd12,
    PH_RA_SET  = 4'd13,
    PH_RA_HIGH = 4'd14
  } phase_e;

  localparam logic [2:0] OP_NONE  = 3'd0;
  localparam logic [2:0] OP_START = 3'd1;
  localparam logic [2:0] OP_STOP  = 3'd2;
  localparam logic [2:0] OP_WRITE = 3'd3;
  localparam logic [2:0] OP_READ  = 3'd4;

  localparam logic [3:0] BYTE_BITS        = 4'd8;
  localparam logic [7:0] PHASE_TICKS_RST  = 8'd6;
  localparam int         IN_DATA_W        = 16;
  localparam int         OUT_DATA_W       = 16;

  typedef struct packed {
    logic       sda_in;
    logic       ack_level;
    logic [7:0] tx_byte;
    logic [2:0] op;
  } req_t;

  typedef struct packed {
    logic       dropped;
    logic       ack_seen;
    logic [7:0] rx_byte;
    logic       done_res;
    logic       busy_res;
    logic       sda_drive;
    logic       scl;
  } res_t;

endpackage

// ----- rtl/i2cm_seq.sv -----
module i2cm_seq
  import i2cm_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       advance_i,
  input  req_t       req_i,
  input  logic [7:0] phase_ticks_i,
  output res_t       res_o
);

  phase_e     phase_q, phase_d;
  logic [3:0] bit_cnt_q, bit_cnt_d;
  logic [7:0] tick_cnt_q, tick_cnt_d;
  logic [7:0] shift_out_q, shift_out_d;
  logic [7:0] shift_in_q, shift_in_d;
  logic       ack_send_q, ack_send_d;
  logic       scl_q, scl_d;
  logic       sda_q, sda_d;
  logic       ack_smp_q, ack_smp_d;
  logic       done;
  logic [7:0] limit;
  logic [7:0] tick_inc;
  logic [3:0] bit_inc;

  assign limit    = (phase_ticks_i == 8'd0) ? 8'd1 : phase_ticks_i;
  assign tick_inc = tick_cnt_q + 8'd1;
  assign bit_inc  = bit_cnt_q + 4'd1;

  always_comb begin
    phase_d     = phase_q;
    bit_cnt_d   = bit_cnt_q;
    tick_cnt_d  = tick_cnt_q;
    shift_out_d = shift_out_q;
    shift_in_d  = shift_in_q;
    ack_send_d  = ack_send_q;
    scl_d       = scl_q;
    sda_d       = sda_q;
    ack_smp_d   = ack_smp_q;
    done        = 1'b0;
    if (phase_q == PH_IDLE) begin
      tick_cnt_d = 8'd0;
      case (req_i.op)
        OP_START: begin
          sda_d = 1'b1; scl_d = 1'b1; phase_d = PH_ST_A;
        end
        OP_STOP: begin
          scl_d = 1'b0; sda_d = 1'b0; phase_d = PH_SP_A;
        end
        OP_WRITE: begin
          scl_d = 1'b0; shift_out_d = req_i.tx_byte; bit_cnt_d = 4'd0;
          phase_d = PH_WR_LOW;
        end
        OP_READ: begin
          sda_d = 1'b1; scl_d = 1'b1; bit_cnt_d = 4'd0;
          ack_send_d = req_i.ack_level; phase_d = PH_RD_HIGH;
        end
        default: ;
      endcase
    end else if (tick_inc < limit) begin
      tick_cnt_d = tick_inc;
    end else begin
      tick_cnt_d = 8'd0;
      case (phase_q)
        PH_ST_A: begin sda_d = 1'b0; phase_d = PH_ST_B; end
        PH_ST_B: begin scl_d = 1'b0; phase_d = PH_IDLE; done = 1'b1; end
        PH_SP_A: begin scl_d = 1'b1; phase_d = PH_SP_B; end
        PH_SP_B: begin sda_d = 1'b1; phase_d = PH_SP_C; end
        PH_SP_C: begin phase_d = PH_IDLE; done = 1'b1; end
        PH_WR_LOW: begin sda_d = shift_out_q[7]; phase_d = PH_WR_DATA; end
        PH_WR_DATA: begin scl_d = 1'b1; phase_d = PH_WR_HIGH; end
        PH_WR_HIGH: begin
          shift_out_d = {shift_out_q[6:0], 1'b0};
          bit_cnt_d   = bit_inc;
          scl_d       = 1'b0;
          if (bit_inc >= BYTE_BITS) begin
            sda_d = 1'b1; phase_d = PH_WA_REL;
          end else begin
            phase_d = PH_WR_LOW;
          end
        end
        PH_WA_REL: begin scl_d = 1'b1; phase_d = PH_WA_HIGH; end
        PH_WA_HIGH: begin
          ack_smp_d = req_i.sda_in; scl_d = 1'b0; phase_d = PH_IDLE; done = 1'b1;
        end
        PH_RD_HIGH: begin
          shift_in_d = {shift_in_q[6:0], req_i.sda_in};
          bit_cnt_d  = bit_inc;
          scl_d      = 1'b0;
          phase_d    = PH_RD_LOW;
        end
        PH_RD_LOW: begin
          if (bit_cnt_q >= BYTE_BITS) begin
            sda_d = ack_send_q; phase_d = PH_RA_SET;
          end else begin
            scl_d = 1'b1; phase_d = PH_RD_HIGH;
          end
        end
        PH_RA_SET: begin scl_d = 1'b1; phase_d = PH_RA_HIGH; end
        PH_RA_HIGH: begin
          scl_d = 1'b0; sda_d = 1'b1; phase_d = PH_IDLE; done = 1'b1;
        end
        default: phase_d = PH_IDLE;
      endcase
    end
  end

  always_comb begin
    res_o.scl       = scl_d;
    res_o.sda_drive = sda_d;
    res_o.busy_res  = (phase_d != PH_IDLE);
    res_o.done_res  = done;
    res_o.rx_byte   = shift_in_d;
    res_o.ack_seen  = ack_smp_d;
    res_o.dropped   = (phase_q != PH_IDLE) && (req_i.op != OP_NONE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      bit_cnt_q   <= 4'd0;
      tick_cnt_q  <= 8'd0;
      shift_out_q <= 8'd0;
      shift_in_q  <= 8'd0;
      ack_send_q  <= 1'b1;
      scl_q       <= 1'b1;
      sda_q       <= 1'b1;
      ack_smp_q   <= 1'b1;
    end else if (advance_i) begin
      phase_q     <= phase_d;
      bit_cnt_q   <= bit_cnt_d;
      tick_cnt_q  <= tick_cnt_d;
      shift_out_q <= shift_out_d;
      shift_in_q  <= shift_in_d;
      ack_send_q  <= ack_send_d;
      scl_q       <= scl_d;
      sda_q       <= sda_d;
      ack_smp_q   <= ack_smp_d;
    end
  end

endmodule

// ----- rtl/i2c_master_bit_engine.sv -----
// An accepted tick's result is registered into out_q, or into skid_q while out_q is held.
// Throughput: a tick per clock if the skid is empty; line state updates once per tick.
// A two-entry output register (main plus skid) keeps s_axis_tready high while one waits.
// Reset (rst_ni low, asynchronous): idle, both lines released, phase_ticks back to 6,
// output queue empty.
module i2c_master_bit_engine
  import i2cm_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // [2:0] op, [10:3] tx_byte, [11] ack_level, [12] sda_in, [15:13] zero
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // [0] scl, [1] sda_drive, [2] busy_res, [3] done_res, [11:4] rx_byte,
  // [12] ack_seen, [13] dropped, [15:14] zero
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [7:0]            cfg_data_i
);

  logic [7:0] phase_ticks_q;
  req_t       req;
  res_t       res;
  logic       accept;
  logic       pop;
  res_t       out_q, skid_q;
  logic       out_vld_q, skid_vld_q;

  assign req           = req_t'(s_axis_tdata[$bits(req_t)-1:0]);
  assign s_axis_tready = !skid_vld_q;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign pop           = out_vld_q && m_axis_tready;
  assign cfg_ready_o   = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_ticks_q <= PHASE_TICKS_RST;
    end else if (cfg_valid_i) begin
      phase_ticks_q <= cfg_data_i;
    end
  end

  i2cm_seq u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .advance_i     (accept),
    .req_i         (req),
    .phase_ticks_i (phase_ticks_q),
    .res_o         (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (skid_vld_q) begin
      if (pop) begin
        skid_vld_q <= 1'b0;
      end
    end else if (accept) begin
      if (out_vld_q && !pop) begin
        skid_vld_q <= 1'b1;
      end else begin
        out_vld_q <= 1'b1;
      end
    end else if (pop) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_vld_q) begin
      if (pop) begin
        out_q <= skid_q;
      end
    end else if (accept) begin
      if (out_vld_q && !pop) begin
        skid_q <= res;
      end else begin
        out_q <= res;
      end
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {{(OUT_DATA_W - $bits(res_t)){1'b0}}, out_q};

endmodule

// ----- rtl/i2cm_checker.sv -----
`include "assert_macros.svh"

module i2cm_checker
  import i2cm_pkg::*;
(
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  m_tvalid_i,
  input logic                  m_tready_i,
  input logic [OUT_DATA_W-1:0] m_tdata_i
);

  res_t r;
  assign r = res_t'(m_tdata_i[$bits(res_t)-1:0]);

  `ASSERT_CLK(a_hold_valid, m_tvalid_i && !m_tready_i |=> m_tvalid_i, "result request dropped")
  `ASSERT_CLK(a_hold_data, m_tvalid_i && !m_tready_i |=> $stable(m_tdata_i), "stalled result changed")
  `ASSERT_IMPL(a_done_idle, m_tvalid_i && r.done_res, !r.busy_res, "done while still busy")
  `ASSERT_IMPL(a_drop_busy, m_tvalid_i && r.dropped && !r.done_res, r.busy_res, "drop while idle")

endmodule

bind i2c_master_bit_engine i2cm_checker u_i2cm_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .m_tvalid_i (m_axis_tvalid),
  .m_tready_i (m_axis_tready),
  .m_tdata_i  (m_axis_tdata)
);
